FILE: hdl/csrm_pkg.sv
// shared types, constants and control records for the cantor set membership core
package csrm_pkg;

   localparam int unsigned VALUE_WIDTH = 32;

   localparam logic [VALUE_WIDTH+1:0] ONE_WIDE = 1;
   // inverse of 3 modulo 2^VALUE_WIDTH
   localparam logic [VALUE_WIDTH+1:0] INV3_WIDE =
      ((VALUE_WIDTH % 2 == 0) ? ((ONE_WIDE << (VALUE_WIDTH + 1)) + ONE_WIDE)
                              : ((ONE_WIDE << VALUE_WIDTH) + ONE_WIDE)) / 3;
   localparam logic [VALUE_WIDTH-1:0] INV3 = INV3_WIDE[VALUE_WIDTH-1:0];
   localparam logic [VALUE_WIDTH-1:0] MAX_VALUE = '1;
   // products at or below this mark come from multiples of 3
   localparam logic [VALUE_WIDTH-1:0] THIRD = MAX_VALUE / 3;

   typedef struct packed {
      logic [31:0] numerator;
      logic [31:0] denominator;
   } req_type;

   typedef struct packed {
      logic in_set;
      logic bad_input;
   } rsp_type;

   typedef struct packed {
      logic load;
      logic mul;
      logic div_q;
      logic mark_start;
      logic sub1;
      logic sub2;
      logic gap;
      logic tri_step;
      logic take_x;
      logic res_we;
      logic res_in_set;
      logic res_bad;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic bad;
      logic div3;
      logic p_eq_q;
      logic dig_one;
      logic tri_one;
      logic x_eq_start;
      logic out_busy;
   } status_type;

endpackage

FILE: hdl/csrm_ctrl.sv
// controller state machine sequencing the digit walk
module csrm_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  csrm_pkg::status_type  status,
   output csrm_pkg::cmd_type     cmd
);

   typedef enum logic [10:0] {
      ST_IDLE  = 11'b00000000001,
      ST_CHKIN = 11'b00000000010,
      ST_MUL   = 11'b00000000100,
      ST_CHK   = 11'b00000001000,
      ST_DIG1  = 11'b00000010000,
      ST_DIG2  = 11'b00000100000,
      ST_GAP   = 11'b00001000000,
      ST_TRI1  = 11'b00010000000,
      ST_TRI2  = 11'b00100000000,
      ST_PCHK  = 11'b01000000000,
      ST_DONE  = 11'b10000000000
   } state_type;

   state_type state_ff;
   state_type state_in;

   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_CHKIN;
            end
         end
         ST_CHKIN: begin
            if (status.bad) begin
               cmd.res_we  = 1'b1;
               cmd.res_bad = 1'b1;
               state_in    = ST_DONE;
            end else begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_CHK;
         end
         ST_CHK: begin
            if (status.div3) begin
               cmd.div_q = 1'b1;
               state_in  = ST_DIG1;
            end else begin
               cmd.mark_start = 1'b1;
               state_in       = ST_GAP;
            end
         end
         ST_DIG1: begin
            if (status.p_eq_q) begin
               cmd.res_we     = 1'b1;
               cmd.res_in_set = 1'b1;
               state_in       = ST_DONE;
            end else begin
               cmd.sub1 = 1'b1;
               state_in = ST_DIG2;
            end
         end
         ST_DIG2: begin
            if (status.dig_one) begin
               cmd.res_we = 1'b1;
               state_in   = ST_DONE;
            end else begin
               cmd.sub2 = 1'b1;
               state_in = ST_MUL;
            end
         end
         ST_GAP: begin
            cmd.gap  = 1'b1;
            state_in = ST_TRI1;
         end
         ST_TRI1: begin
            cmd.tri_step = 1'b1;
            state_in     = ST_TRI2;
         end
         ST_TRI2: begin
            cmd.tri_step = 1'b1;
            state_in     = ST_PCHK;
         end
         ST_PCHK: begin
            if (status.tri_one) begin
               cmd.res_we = 1'b1;
               state_in   = ST_DONE;
            end else if (status.x_eq_start) begin
               cmd.res_we     = 1'b1;
               cmd.res_in_set = 1'b1;
               state_in       = ST_DONE;
            end else begin
               cmd.take_x = 1'b1;
               state_in   = ST_GAP;
            end
         end
         ST_DONE: begin
            if (!status.out_busy) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: hdl/csrm_datapath.sv
// datapath: operand registers, divide-by-3 multiplier, digit subtractors, result register
module csrm_datapath (
   input  logic                  clock,
   input  logic                  reset,
   input  csrm_pkg::req_type     req_data,
   input  csrm_pkg::cmd_type     cmd,
   output csrm_pkg::status_type  status,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output csrm_pkg::rsp_type     rsp_data
);

   localparam int unsigned W = csrm_pkg::VALUE_WIDTH;

   logic [W-1:0]   p_ff, q_ff, start_ff, gap_ff, x_ff, prod_ff;
   logic [W-1:0]   p_in, q_in, start_in, gap_in, x_in, prod_in;
   logic           one_ff, one_in;
   logic [1:0]     tdig_ff, tdig_in;
   logic           res_in_set_ff, res_bad_ff;
   logic           rsp_valid_ff, rsp_valid_in;
   csrm_pkg::rsp_type rsp_data_ff;
   logic [W-1:0]   mul_full;
   logic           p_ge_q;
   logic           x_ge_gap;

   assign mul_full = q_ff * csrm_pkg::INV3;
   assign p_ge_q   = (p_ff >= q_ff);
   assign x_ge_gap = (x_ff >= gap_ff);

   assign status.bad        = (q_ff == '0) || p_ge_q;
   assign status.div3       = (prod_ff <= csrm_pkg::THIRD);
   assign status.p_eq_q     = (p_ff == q_ff);
   assign status.dig_one    = one_ff && !p_ge_q;
   assign status.tri_one    = (tdig_ff == 2'd1);
   assign status.x_eq_start = (x_ff == start_ff);
   assign status.out_busy   = rsp_valid_ff && rsp_stall;

   always_comb begin
      p_in     = p_ff;
      q_in     = q_ff;
      start_in = start_ff;
      gap_in   = gap_ff;
      x_in     = x_ff;
      prod_in  = prod_ff;
      one_in   = one_ff;
      tdig_in  = tdig_ff;
      if (cmd.load) begin
         p_in = req_data.numerator[W-1:0];
         q_in = req_data.denominator[W-1:0];
      end
      if (cmd.mul) begin
         prod_in = mul_full;
      end
      if (cmd.div_q) begin
         q_in = prod_ff;
      end
      if (cmd.mark_start) begin
         start_in = p_ff;
      end
      if (cmd.sub1) begin
         one_in = p_ge_q;
         if (p_ge_q) begin
            p_in = p_ff - q_ff;
         end
      end
      if (cmd.sub2 && p_ge_q) begin
         p_in = p_ff - q_ff;
      end
      if (cmd.gap) begin
         gap_in  = q_ff - p_ff;
         x_in    = p_ff;
         tdig_in = 2'd0;
      end
      if (cmd.tri_step) begin
         if (x_ge_gap) begin
            x_in    = x_ff - gap_ff;
            tdig_in = tdig_ff + 2'd1;
         end else begin
            x_in = x_ff + p_ff;
         end
      end
      if (cmd.take_x) begin
         p_in = x_ff;
      end
   end

   always_ff @(posedge clock) begin
      p_ff     <= p_in;
      q_ff     <= q_in;
      start_ff <= start_in;
      gap_ff   <= gap_in;
      x_ff     <= x_in;
      prod_ff  <= prod_in;
      one_ff   <= one_in;
      tdig_ff  <= tdig_in;
      if (cmd.res_we) begin
         res_in_set_ff <= cmd.res_in_set;
         res_bad_ff    <= cmd.res_bad;
      end
      if (cmd.out_load) begin
         rsp_data_ff.in_set    <= res_in_set_ff;
         rsp_data_ff.bad_input <= res_bad_ff;
      end
   end

   assign rsp_valid_in = cmd.out_load || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

FILE: hdl/cantor_set_rational_membership_core.sv
// top level of the cantor set membership core for fractions p/q
// Decides whether numerator/denominator lies in the middle-thirds Cantor set and
// flags q = 0 or p >= q as bad input; one item is worked at a time. From acceptance
// to the next possible acceptance an item goes through an input check; for each
// factor of 3 removed from q, a divide-by-3 multiply, a divisibility check and
// two compare-subtract steps; a multiply and check that find q free of 3; for each
// periodic base-3 digit walked, a gap step, two triple-and-reduce steps and a
// check; a result register load and an idle state. The digits walked number at
// most the multiplicative order of 3 modulo the reduced q and may reach q - 1. A bad
// input goes from the input check straight to the result load; a rejecting digit
// ends the walk early. The result load waits while the previous result is still
// stalled; the next item is taken as soon as the result is in the output register.
module cantor_set_rational_membership_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  csrm_pkg::req_type  req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output csrm_pkg::rsp_type  rsp_data
);

   csrm_pkg::cmd_type    cmd;
   csrm_pkg::status_type status;

   csrm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   csrm_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   a_bad_not_in_set: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_data.bad_input && rsp_data.in_set))
      else $error("bad item reported as member");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("second item taken while one is in work");

   a_result_from_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result appeared with no item in work");

   a_one_load_per_item: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(cmd.load))
      else $error("result issued in the cycle an item was taken");

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 1ps
// self-checking testbench for the cantor set membership core
module tb_top;

   localparam int unsigned QUIET_LIMIT      = 2_000_000;
   localparam int unsigned RANDOM_PER_PHASE = 185;
   localparam int unsigned TAIL_CYCLES      = 64;
   localparam logic [31:0] POW3_19          = 32'd1162261467;
   localparam logic [31:0] POW3_20          = 32'd3486784401;
   localparam logic [31:0] ALL_ONES         = 32'hFFFF_FFFF;

   typedef struct packed {
      csrm_pkg::req_type frac;
      logic              known;
      csrm_pkg::rsp_type verdict;
   } probe_row_type;

   logic              clock     = 1'b0;
   logic              reset     = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   csrm_pkg::req_type req_data  = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   csrm_pkg::rsp_type rsp_data;

   probe_row_type probe_q[$];
   probe_row_type awaited_q[$];
   probe_row_type next_awaited = '0;
   int unsigned req_idle_pct = 0;
   int unsigned rsp_idle_pct = 0;
   int unsigned fractions_taken = 0;
   int unsigned verdicts_checked = 0;
   int unsigned members_seen = 0;
   int unsigned bad_seen = 0;
   int unsigned mismatches = 0;
   int unsigned quiet_cycles = 0;
   int unsigned n_periodic = 0;
   int unsigned n_endpoint = 0;
   int unsigned n_spoiled = 0;
   int unsigned n_noise = 0;

   cantor_set_rational_membership_core DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic longint unsigned pow3(input int unsigned n);
      longint unsigned acc;
      acc = 1;
      repeat (n) acc = acc * 3;
      return acc;
   endfunction

   // walks the base-3 digits of num/den the way the core does
   function automatic csrm_pkg::rsp_type cantor_verdict(input csrm_pkg::req_type frac);
      longint unsigned   num;
      longint unsigned   den;
      longint unsigned   origin;
      longint unsigned   digit;
      csrm_pkg::rsp_type verdict;
      num = 64'(frac.numerator);
      den = 64'(frac.denominator);
      verdict = '0;
      if (den == 0 || num >= den) begin
         verdict.bad_input = 1'b1;
         return verdict;
      end
      while (den % 3 == 0) begin
         den = den / 3;
         // a middle digit with nothing after it is an endpoint
         if (num == den) begin
            verdict.in_set = 1'b1;
            return verdict;
         end
         digit = num / den;
         num = num % den;
         if (digit == 1) return verdict;
      end
      origin = num;
      do begin
         digit = (3 * num) / den;
         num = (3 * num) % den;
         if (digit == 1) return verdict;
      end while (num != origin);
      verdict.in_set = 1'b1;
      return verdict;
   endfunction

   function automatic void add_probe(input logic [31:0] num, input logic [31:0] den,
                                     input logic known, input logic in_set,
                                     input logic bad);
      probe_row_type row;
      row.frac.numerator = num;
      row.frac.denominator = den;
      row.known = known;
      row.verdict.in_set = in_set;
      row.verdict.bad_input = bad;
      probe_q.insert(probe_q.size(), row);
   endfunction

   // mostly fractions built from 0/2 digits, some spoiled by one middle digit, plus noise
   function automatic csrm_pkg::req_type make_fraction();
      csrm_pkg::req_type frac;
      longint unsigned   lead;
      longint unsigned   body;
      longint unsigned   span;
      longint unsigned   digit;
      int unsigned       len_rep;
      int unsigned       len_lead;
      int unsigned       pick;
      int unsigned       spoil_at;
      int unsigned       i;
      bit                spoil;
      frac = '0;
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
         len_rep = $urandom_range(1, 20);
         len_lead = $urandom_range(0, 20 - len_rep);
         spoil = ($urandom_range(0, 3) == 0);
         spoil_at = $urandom_range(0, len_rep + len_lead - 1);
         lead = 0;
         body = 0;
         for (i = 0; i < len_lead + len_rep; i++) begin
            digit = (spoil && i == spoil_at) ? 1 : 2 * $urandom_range(0, 1);
            if (i < len_lead) lead = lead * 3 + digit;
            else body = body * 3 + digit;
         end
         span = pow3(len_rep) - 1;
         frac.numerator = 32'(lead * span + body);
         frac.denominator = 32'(pow3(len_lead) * span);
         if (spoil) n_spoiled++;
         else n_periodic++;
      end else if (pick < 62) begin
         len_lead = $urandom_range(0, 19);
         lead = 0;
         repeat (len_lead) lead = lead * 3 + 2 * $urandom_range(0, 1);
         frac.numerator = 32'(3 * lead + 1);
         frac.denominator = 32'(pow3(len_lead + 1));
         n_endpoint++;
      end else if (pick < 78) begin
         frac.denominator = $urandom_range(1, 3000);
         frac.numerator = $urandom_range(0, frac.denominator - 1);
         n_noise++;
      end else if (pick < 92) begin
         frac.denominator = $urandom;
         frac.numerator = $urandom;
         if (frac.denominator != 0 && $urandom_range(0, 1) == 1)
            frac.numerator = frac.numerator % frac.denominator;
         n_noise++;
      end else begin
         frac.numerator = $urandom;
         frac.denominator = $urandom_range(0, frac.numerator);
         n_noise++;
      end
      return frac;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("MISMATCH at %0t: %s", $time, msg);
      mismatches++;
   endtask

   task automatic send_fraction(input csrm_pkg::req_type frac,
                                input csrm_pkg::rsp_type verdict);
      int unsigned gap;
      int unsigned mark;
      gap = 0;
      while ($urandom_range(0, 99) < req_idle_pct) gap++;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      next_awaited.frac = frac;
      next_awaited.known = 1'b1;
      next_awaited.verdict = verdict;
      req_data <= frac;
      req_valid <= 1'b1;
      mark = fractions_taken;
      do @(negedge clock); while (fractions_taken == mark);
   endtask

   task automatic drain_verdicts();
      req_valid <= 1'b0;
      do @(negedge clock); while (awaited_q.size() != 0);
   endtask

   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < rsp_idle_pct);
   end

   always @(posedge clock) begin
      probe_row_type head;
      bit            moved;
      moved = 1'b0;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            awaited_q.insert(awaited_q.size(), next_awaited);
            fractions_taken++;
            moved = 1'b1;
         end
         if (rsp_valid && !rsp_stall) begin
            verdicts_checked++;
            moved = 1'b1;
            if (rsp_data.in_set === 1'b1 && rsp_data.bad_input === 1'b0) members_seen++;
            if (rsp_data.bad_input === 1'b1) bad_seen++;
            if (awaited_q.size() == 0) begin
               report_mismatch($sformatf("result %b with no item outstanding", rsp_data));
            end else begin
               head = awaited_q.pop_front();
               if (rsp_data.in_set !== head.verdict.in_set)
                  report_mismatch($sformatf("%0d/%0d in_set got %b want %b",
                     head.frac.numerator, head.frac.denominator,
                     rsp_data.in_set, head.verdict.in_set));
               if (rsp_data.bad_input !== head.verdict.bad_input)
                  report_mismatch($sformatf("%0d/%0d bad_input got %b want %b",
                     head.frac.numerator, head.frac.denominator,
                     rsp_data.bad_input, head.verdict.bad_input));
            end
         end
         quiet_cycles = moved ? 0 : quiet_cycles + 1;
      end
   end

   initial begin
      while (quiet_cycles < QUIET_LIMIT) @(negedge clock);
      $display("simulation failed");
      $finish;
   end

   initial begin
      probe_row_type     row;
      csrm_pkg::req_type frac;
      int unsigned       phase;
      // bad inputs
      add_probe(32'd0, 32'd0, 1'b1, 1'b0, 1'b1);
      add_probe(32'd5, 32'd0, 1'b1, 1'b0, 1'b1);
      add_probe(ALL_ONES, 32'd0, 1'b1, 1'b0, 1'b1);
      add_probe(32'd7, 32'd7, 1'b1, 1'b0, 1'b1);
      add_probe(ALL_ONES, ALL_ONES, 1'b1, 1'b0, 1'b1);
      add_probe(ALL_ONES, 32'd1, 1'b1, 1'b0, 1'b1);
      add_probe(POW3_20, POW3_19, 1'b1, 1'b0, 1'b1);
      // zero, the endpoints and a point just past one
      add_probe(32'd0, 32'd1, 1'b1, 1'b1, 1'b0);
      add_probe(32'd0, ALL_ONES, 1'b1, 1'b1, 1'b0);
      add_probe(32'd1, 32'd3, 1'b1, 1'b1, 1'b0);
      add_probe(32'd2, 32'd3, 1'b1, 1'b1, 1'b0);
      add_probe(POW3_19, POW3_20, 1'b1, 1'b1, 1'b0);
      add_probe(32'd1, POW3_20, 1'b1, 1'b1, 1'b0);
      add_probe(POW3_20 - 32'd1, POW3_20, 1'b1, 1'b1, 1'b0);
      add_probe(POW3_19 + 32'd1, POW3_20, 1'b1, 1'b0, 1'b0);
      // periodic digits, checked against the predictor
      add_probe(32'd1, 32'd2, 1'b0, 1'b0, 1'b0);
      add_probe(32'd1, 32'd4, 1'b0, 1'b0, 1'b0);
      add_probe(32'd3, 32'd4, 1'b0, 1'b0, 1'b0);
      add_probe(32'd1, 32'd10, 1'b0, 1'b0, 1'b0);
      add_probe(32'd3, 32'd10, 1'b0, 1'b0, 1'b0);
      add_probe(ALL_ONES - 32'd1, ALL_ONES, 1'b0, 1'b0, 1'b0);
      add_probe(32'd1, ALL_ONES, 1'b0, 1'b0, 1'b0);
      add_probe(32'h5555_5555, 32'hAAAA_AAAB, 1'b0, 1'b0, 1'b0);
      add_probe(32'h8000_0000, 32'hC000_0001, 1'b0, 1'b0, 1'b0);

      repeat (8) @(negedge clock);
      reset <= 1'b0;
      for (phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               req_idle_pct = 24;
               rsp_idle_pct = 57;
            end
            1: begin
               req_idle_pct = 57;
               rsp_idle_pct = 24;
            end
            default: begin
               req_idle_pct = 0;
               rsp_idle_pct = 0;
            end
         endcase
         if (phase == 0) begin
            foreach (probe_q[i]) begin
               row = probe_q[i];
               send_fraction(row.frac, row.known ? row.verdict : cantor_verdict(row.frac));
            end
         end
         repeat (RANDOM_PER_PHASE) begin
            frac = make_fraction();
            send_fraction(frac, cantor_verdict(frac));
         end
         drain_verdicts();
      end
      repeat (TAIL_CYCLES) @(negedge clock);

      $display("fractions sent: %0d periodic members, %0d endpoints, %0d with a middle digit,",
               n_periodic, n_endpoint, n_spoiled);
      $display("  %0d other, %0d table rows; %0d results checked (%0d in the set, %0d bad)",
               n_noise, probe_q.size(), verdicts_checked, members_seen, bad_seen);
      if (mismatches == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
